### hdl/slo_pkg.sv
// shared types, constants and codes of the slew limiter with oscillation damping
package slo_pkg;

   localparam int CHANNELS = 256;
   localparam int CHAN_W   = $clog2(CHANNELS);

   localparam int ID_W    = 8;
   localparam int VAL_W   = 32;
   localparam int RISK_W  = 32;
   localparam int REG_W   = 31;
   localparam int RESID_W = 32;
   localparam int RSUM_W  = 48;
   localparam int KSUM_W  = 63;
   localparam int FRAC_W  = 24;
   localparam int PROD_W  = VAL_W + RISK_W;
   localparam int PSH_W   = PROD_W - FRAC_W;

   localparam logic [REG_W-1:0] MAX_DRIFT_RST = 31'd838861;
   localparam logic [REG_W-1:0] OSC_TOL_RST   = 31'd1678;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DRIFT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OSC_TOL   = 4'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_DAMPED  = 2'd1,
      ACT_CLAMPED = 2'd2,
      ACT_BOTH    = 2'd3
   } action_type;

   typedef struct packed {
      logic [ID_W-1:0]          channel_id;
      logic signed [VAL_W-1:0]  proposed_value;
      logic [RISK_W-1:0]        risk_weight;
      logic                     last_item;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]  adjusted_value;
      action_type               action;
      logic [RESID_W-1:0]       residual;
      logic [RSUM_W-1:0]        resid_total;
      logic [KSUM_W-1:0]        risk_sum;
      logic                     batch_done;
   } rsp_type;

   // request plus what the front found out about its channel
   typedef struct packed {
      req_type req;
      logic    seen;
   } item_type;

   typedef struct packed {
      logic [REG_W-1:0] max_drift;
      logic [REG_W-1:0] osc_tol;
   } cfg_type;

   // one history entry: last value and the one before it
   typedef struct packed {
      logic signed [VAL_W-1:0] last;
      logic signed [VAL_W-1:0] prior;
   } hist_type;

endpackage

### hdl/slo_front.sv
// front end: accepts requests, tracks which channels have history, tags each request
module slo_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  slo_pkg::req_type   req_data,
   output logic               push_valid,
   input  logic               push_ready,
   output slo_pkg::item_type  push_item
);

   logic [slo_pkg::CHANNELS-1:0] seen_ff;
   logic [slo_pkg::CHANNELS-1:0] seen_in;
   logic [slo_pkg::CHAN_W-1:0]   ch;
   logic                         req_fire;

   assign ch         = req_data.channel_id[slo_pkg::CHAN_W-1:0];
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign req_fire   = req_valid && push_ready;

   always_comb begin
      push_item.req  = req_data;
      push_item.seen = seen_ff[ch];
   end

   // history flags are set in request order, so they match what the back end will see
   always_comb begin
      seen_in = seen_ff;
      if (req_fire) begin
         seen_in[ch] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

### hdl/slo_queue.sv
// small fifo between the front end and the back end
module slo_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  slo_pkg::item_type  push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output slo_pkg::item_type  pop_item
);

   slo_pkg::item_type          entries_ff [slo_pkg::QUEUE_DEPTH];
   logic [slo_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [slo_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [slo_pkg::QPTR_W:0]   count_ff;
   logic [slo_pkg::QPTR_W:0]   count_in;
   logic                       push_fire;
   logic                       pop_fire;

   assign push_ready = count_ff != (slo_pkg::QPTR_W + 1)'(slo_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_fire) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_fire) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/slo_back.sv
// back end: history ram, damping and clamping, risk product and batch sums
module slo_back (
   input  logic               clock,
   input  logic               reset,
   input  slo_pkg::cfg_type   cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  slo_pkg::item_type  pop_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output slo_pkg::rsp_type   rsp_data
);

   localparam int W = slo_pkg::VAL_W;

   // history ram, read port registered
   slo_pkg::hist_type mem [slo_pkg::CHANNELS];
   slo_pkg::hist_type rd_data_ff;
   slo_pkg::hist_type fwd_ff;
   logic              use_fwd_ff;

   // stage 1: update
   logic                       s1_valid_ff, s1_valid_in;
   slo_pkg::item_type          s1_item_ff;
   logic                       s1_ready, s1_fire, pop_fire;
   logic [slo_pkg::CHAN_W-1:0] pop_ch, s1_ch;
   slo_pkg::hist_type          hist, s1_wr;
   logic signed [W-1:0]        w, wp, cur;
   logic signed [W:0]          d1, dt, e, e_sel, lim_s;
   logic signed [W+1:0]        d1_x, dt_x, tol_x, ntol_x, sum_x;
   logic [W:0]                 abs_e;
   logic                       damp, clamped;
   slo_pkg::action_type        act;

   // stage 2: multiply
   logic                            s2_valid_ff, s2_valid_in, s2_ready, s2_fire;
   logic signed [W-1:0]             s2_cur_ff, s2_w_ff;
   logic [slo_pkg::RISK_W-1:0]      s2_risk_ff;
   logic                            s2_last_ff;
   slo_pkg::action_type             s2_act_ff;
   logic [W:0]                      step, step_abs;
   logic [W-1:0]                    abs_cur;
   logic [slo_pkg::PROD_W-1:0]      prod;

   // stage 3: accumulate
   logic                            s3_valid_ff, s3_valid_in, s3_ready, s3_fire;
   logic [slo_pkg::PSH_W-1:0]       s3_prod_ff;
   logic [slo_pkg::RESID_W-1:0]     s3_resid_ff;
   logic signed [W-1:0]             s3_cur_ff;
   logic                            s3_last_ff;
   slo_pkg::action_type             s3_act_ff;
   logic [slo_pkg::RSUM_W-1:0]      racc_ff, racc_in, rsum_sat;
   logic [slo_pkg::KSUM_W-1:0]      kacc_ff, kacc_in, ksum_sat;
   logic [slo_pkg::RSUM_W:0]        rsum;
   logic [slo_pkg::KSUM_W:0]        ksum;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   slo_pkg::rsp_type  rsp_data_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // handshakes between stages
   assign s3_ready  = !rsp_valid_ff || rsp_ready;
   assign s3_fire   = s3_valid_ff && s3_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s2_fire   = s2_valid_ff && s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s1_fire   = s1_valid_ff && s2_ready;
   assign pop_ready = s1_ready;
   assign pop_fire  = pop_valid && s1_ready;

   assign pop_ch = pop_item.req.channel_id[slo_pkg::CHAN_W-1:0];
   assign s1_ch  = s1_item_ff.req.channel_id[slo_pkg::CHAN_W-1:0];

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         rd_data_ff <= mem[pop_ch];
      end
      if (s1_fire) begin
         mem[s1_ch] <= s1_wr;
      end
   end

   // the ram read misses a write to the same channel made on the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         use_fwd_ff <= 1'b0;
      end else if (pop_fire) begin
         use_fwd_ff <= s1_fire && (s1_ch == pop_ch);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         fwd_ff <= s1_wr;
      end
      if (pop_fire) begin
         s1_item_ff <= pop_item;
      end
   end

   // damping and clamping
   always_comb begin
      hist   = use_fwd_ff ? fwd_ff : rd_data_ff;
      w      = s1_item_ff.seen ? hist.last : '0;
      wp     = s1_item_ff.seen ? hist.prior : '0;
      d1     = {s1_item_ff.req.proposed_value[W-1], s1_item_ff.req.proposed_value}
               - {w[W-1], w};
      dt     = {w[W-1], w} - {wp[W-1], wp};
      d1_x   = {d1[W], d1};
      dt_x   = {dt[W], dt};
      tol_x  = {3'b000, cfg.osc_tol};
      ntol_x = -tol_x;
      damp   = s1_item_ff.seen &&
               ((dt_x > tol_x && d1_x < ntol_x) || (dt_x < ntol_x && d1_x > tol_x));
      e      = damp ? (d1 >>> 1) : d1;
      abs_e  = e[W] ? -e : e;
      lim_s  = {2'b00, cfg.max_drift};
      clamped = abs_e > {2'b00, cfg.max_drift};
      if (clamped) begin
         e_sel = e[W] ? -lim_s : lim_s;
      end else begin
         e_sel = e;
      end
      sum_x = {w[W-1], w[W-1], w} + {e_sel[W], e_sel};
      // saturate to 32 bits
      if (sum_x[W+1:W-1] == 3'b000 || sum_x[W+1:W-1] == 3'b111) begin
         cur = sum_x[W-1:0];
      end else if (sum_x[W+1]) begin
         cur = {1'b1, {(W-1){1'b0}}};
      end else begin
         cur = {1'b0, {(W-1){1'b1}}};
      end
      s1_wr.last  = cur;
      s1_wr.prior = w;
      if (damp) begin
         act = clamped ? slo_pkg::ACT_BOTH : slo_pkg::ACT_DAMPED;
      end else begin
         act = clamped ? slo_pkg::ACT_CLAMPED : slo_pkg::ACT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_cur_ff  <= cur;
         s2_w_ff    <= w;
         s2_risk_ff <= s1_item_ff.req.risk_weight;
         s2_last_ff <= s1_item_ff.req.last_item;
         s2_act_ff  <= act;
      end
   end

   // residual and risk product
   always_comb begin
      step     = {s2_cur_ff[W-1], s2_cur_ff} - {s2_w_ff[W-1], s2_w_ff};
      step_abs = step[W] ? -step : step;
      abs_cur  = s2_cur_ff[W-1] ? -s2_cur_ff : s2_cur_ff;
      prod     = slo_pkg::PROD_W'(abs_cur) * slo_pkg::PROD_W'(s2_risk_ff);
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         s3_prod_ff  <= prod[slo_pkg::PROD_W-1:slo_pkg::FRAC_W];
         s3_resid_ff <= step_abs[slo_pkg::RESID_W-1:0];
         s3_cur_ff   <= s2_cur_ff;
         s3_last_ff  <= s2_last_ff;
         s3_act_ff   <= s2_act_ff;
      end
   end

   // saturating batch sums
   always_comb begin
      rsum     = {1'b0, racc_ff} + (slo_pkg::RSUM_W + 1)'(s3_resid_ff);
      rsum_sat = rsum[slo_pkg::RSUM_W] ? '1 : rsum[slo_pkg::RSUM_W-1:0];
      ksum     = {1'b0, kacc_ff} + (slo_pkg::KSUM_W + 1)'(s3_prod_ff);
      ksum_sat = ksum[slo_pkg::KSUM_W] ? '1 : ksum[slo_pkg::KSUM_W-1:0];
      racc_in  = racc_ff;
      kacc_in  = kacc_ff;
      if (s3_fire) begin
         racc_in = s3_last_ff ? '0 : rsum_sat;
         kacc_in = s3_last_ff ? '0 : ksum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_fire) begin
         rsp_data_ff.adjusted_value <= s3_cur_ff;
         rsp_data_ff.action         <= s3_act_ff;
         rsp_data_ff.residual       <= s3_resid_ff;
         rsp_data_ff.resid_total    <= s3_last_ff ? rsum_sat : '0;
         rsp_data_ff.risk_sum       <= s3_last_ff ? ksum_sat : '0;
         rsp_data_ff.batch_done     <= s3_last_ff;
      end
   end

   always_comb begin
      s1_valid_in  = pop_fire || (s1_valid_ff && !s1_fire);
      s2_valid_in  = s1_fire || (s2_valid_ff && !s2_fire);
      s3_valid_in  = s2_fire || (s3_valid_ff && !s3_fire);
      rsp_valid_in = s3_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         racc_ff      <= '0;
         kacc_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         racc_ff      <= racc_in;
         kacc_ff      <= kacc_in;
      end
   end

endmodule

### hdl/slew_limiter_oscillation_damper_top.sv
// Per-channel slew limiter with oscillation damping.
// Requests come in on req_valid/req_ready/req_data: a channel, a proposed signed
// Q8.24 value, an unsigned Q8.24 risk weight and a last-of-batch flag. Results
// leave on rsp_valid/rsp_ready/rsp_data, one per request and in request order.
// max_drift and oscillation_tolerance are written on csr_valid/csr_index/csr_wdata;
// csr_ready is always high; the user must make writes only while the block is idle,
// which the block does not enforce. A request accepted passes the queue and the update,
// multiply and accumulate stages into the output register. One request per cycle is
// sustained while the receiver takes results, also when the same channel comes back to
// back: the history ram read is bypassed by the value written on the same edge. The
// front end tracks seen channels in flip-flops; the back end holds the last two values
// per channel in a ram with one read port and one write port, each used once per cycle.
// A four-entry queue splits the two, so requests keep flowing while the pipeline drains
// into a stalled receiver; once queue and pipeline are full, req_ready drops. Reset
// clears the seen flags, the batch sums, the pipeline and loads the registers with their defaults.
module slew_limiter_oscillation_damper_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  slo_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output slo_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [slo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [slo_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   slo_pkg::cfg_type   cfg_ff;
   slo_pkg::cfg_type   cfg_in;
   logic               push_valid, push_ready;
   slo_pkg::item_type  push_item;
   logic               pop_valid, pop_ready;
   slo_pkg::item_type  pop_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            slo_pkg::CSR_MAX_DRIFT: cfg_in.max_drift = csr_wdata[slo_pkg::REG_W-1:0];
            slo_pkg::CSR_OSC_TOL:   cfg_in.osc_tol   = csr_wdata[slo_pkg::REG_W-1:0];
            default: begin
               // unknown index, ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_drift <= slo_pkg::MAX_DRIFT_RST;
         cfg_ff.osc_tol   <= slo_pkg::OSC_TOL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   slo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   slo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/slo_checker.sv
// port-level checks for the slew limiter, bound to the top level
module slo_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  slo_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  slo_pkg::rsp_type  rsp_data
);

   localparam int MAX_INFLIGHT = slo_pkg::QUEUE_DEPTH + 4;
   localparam int CNT_W        = $clog2(MAX_INFLIGHT + 1);

   logic [CNT_W-1:0] inflight_ff;
   logic [CNT_W-1:0] inflight_in;
   logic             req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_fire && !rsp_fire) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not empty the block");

   a_sums_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.batch_done |->
         rsp_data.resid_total == '0 && rsp_data.risk_sum == '0)
      else $error("batch sums shown before batch end");

   a_sum_covers_residual: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.batch_done |->
         rsp_data.resid_total >= slo_pkg::RSUM_W'(rsp_data.residual))
      else $error("residual sum smaller than last residual");

   a_no_phantom_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0 && inflight_ff <= CNT_W'(MAX_INFLIGHT))
      else $error("result without a pending request");

endmodule

bind slew_limiter_oscillation_damper_top slo_checker u_checker (.*);
